// ===== sv/enms_pkg.sv =====
// Shared types, constants and the angle quantizer for the edge non-maximum
// suppression block. This package has no dependencies; the top level, front,
// window and bench import it; the line store does not.
package enms_pkg;

  // Fixed field widths.
  localparam int CFG_W      = 11;
  localparam int ROW_W      = 10;
  localparam int COORD_W    = 10;
  localparam int FIELD_W    = 16;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 40;
  localparam int MAX_HEIGHT = 1024;

  // Configuration register indexes.
  localparam logic CFG_IDX_WIDTH  = 1'b0;
  localparam logic CFG_IDX_HEIGHT = 1'b1;

  // Gradient directions after folding into [0, pi).
  typedef enum logic [1:0] {
    DIR_HORZ      = 2'd0,  // left and right
    DIR_DIAG_UP   = 2'd1,  // lower-left and upper-right
    DIR_VERT      = 2'd2,  // above and below
    DIR_DIAG_DOWN = 2'd3   // upper-left and lower-right
  } dir_t;

  // Sector boundaries at odd multiples of pi/8 in Q2.13.
  localparam logic signed [15:0] ANG_P1 = 16'sd3216;
  localparam logic signed [15:0] ANG_P3 = 16'sd9650;
  localparam logic signed [15:0] ANG_P5 = 16'sd16084;
  localparam logic signed [15:0] ANG_P7 = 16'sd22518;
  localparam logic signed [15:0] ANG_N7 = -16'sd22519;
  localparam logic signed [15:0] ANG_N5 = -16'sd16085;
  localparam logic signed [15:0] ANG_N3 = -16'sd9651;
  localparam logic signed [15:0] ANG_N1 = -16'sd3217;

  // Control that travels with a pixel from the address stage to the window.
  typedef struct packed {
    logic               emit;
    logic               last;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
  } pix_ctl_t;

  // Negative angles fold by pi, so both halves map onto the same four sectors.
  function automatic dir_t quantize(input logic signed [15:0] a);
    dir_t d;
    if (!a[15]) begin
      if (a <= ANG_P1)      d = DIR_HORZ;
      else if (a <= ANG_P3) d = DIR_DIAG_UP;
      else if (a <= ANG_P5) d = DIR_VERT;
      else if (a <= ANG_P7) d = DIR_DIAG_DOWN;
      else                  d = DIR_HORZ;
    end else begin
      if (a <= ANG_N7)      d = DIR_HORZ;
      else if (a <= ANG_N5) d = DIR_DIAG_UP;
      else if (a <= ANG_N3) d = DIR_VERT;
      else if (a <= ANG_N1) d = DIR_DIAG_DOWN;
      else                  d = DIR_HORZ;
    end
    return d;
  endfunction

endpackage

// ===== sv/edge_non_max_suppression.sv =====
// Top level of the edge non-maximum suppression block.
// Depends on enms_pkg, enms_front, enms_line_ram and enms_window.
//
// Pixels arrive in raster order on the in_ stream, one beat per pixel;
// in_tuser marks the first pixel of a frame and restarts the raster position.
// The user sets frame width and height on the cfg_ write port only while the
// block is idle (not enforced); out-of-range values clamp to 3..MAX_WIDTH, 3..1024.
// For each interior pixel (r, c) one beat leaves on the out_ stream with the
// suppressed magnitude and its coordinates, when pixel (r+1, c+1) has been
// taken; border pixels produce no beat. out_tlast flags the last interior
// pixel of the frame.
// Throughput is one pixel per clock unless out_tready stalls the output. After
// the beat of pixel (r+1, c+1) is accepted, its result passes the line store
// read register, then the window compare into the output register.
// The two line stores and the direction line share one memory, read and
// written once per pixel; a same-column read and write in one cycle is bypassed.
// Reset clears the position counters, the window and the pipeline valids and
// restores a min(MAX_WIDTH, 1024) by 1024 geometry; the line stores are not cleared.
// When out_tready is low the output register holds and in_tready drops only
// once a pixel that would yield a result is waiting behind it.
module edge_non_max_suppression #(
  parameter int MAX_WIDTH = 1024,
  parameter int MAG_BITS  = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_idx,
  input  logic [10:0] cfg_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // magnitude[15:0], angle[31:16]
  input  logic        in_tuser,   // frame_start
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // suppressed[15:0], out_row[25:16], out_col[35:26]
  output logic        out_tlast   // last
);

  import enms_pkg::*;

  localparam int MAG_W = (MAG_BITS < FIELD_W) ? MAG_BITS : FIELD_W;
  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int RAM_W = 2 + 2 * MAG_W;

  logic             s1_go, s1_valid, rd_en;
  logic [COL_W-1:0] rd_addr, s1_col;
  logic [MAG_W-1:0] s1_mag;
  dir_t             s1_dir;
  pix_ctl_t         s1_ctl;
  logic [RAM_W-1:0] ram_q, ram_d;
  logic [MAG_W-1:0] upper_rd, middle_rd;
  dir_t             dir_rd;

  enms_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAG_W     (MAG_W),
    .COL_W     (COL_W)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_idx        (cfg_idx),
    .cfg_data       (cfg_data),
    .in_valid       (in_tvalid),
    .in_ready       (in_tready),
    .in_mag         (MAG_W'(in_tdata[15:0])),
    .in_angle       (in_tdata[31:16]),
    .in_frame_start (in_tuser),
    .s1_go          (s1_go),
    .rd_en          (rd_en),
    .rd_addr        (rd_addr),
    .s1_valid       (s1_valid),
    .s1_col         (s1_col),
    .s1_mag         (s1_mag),
    .s1_dir         (s1_dir),
    .s1_ctl         (s1_ctl)
  );

  // Entry layout: upper line, middle line, middle direction from the low bit.
  assign upper_rd  = ram_q[MAG_W-1:0];
  assign middle_rd = ram_q[2*MAG_W-1:MAG_W];
  assign dir_rd    = dir_t'(ram_q[RAM_W-1:2*MAG_W]);
  assign ram_d     = {s1_dir, s1_mag, middle_rd};

  enms_line_ram #(
    .DEPTH (MAX_WIDTH),
    .AW    (COL_W),
    .DW    (RAM_W)
  ) u_lines (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (ram_q),
    .wr_en   (s1_go),
    .wr_addr (s1_col),
    .wr_data (ram_d)
  );

  enms_window #(
    .MAG_W (MAG_W)
  ) u_window (
    .clk       (clk),
    .rst_n     (rst_n),
    .s1_valid  (s1_valid),
    .s1_ctl    (s1_ctl),
    .s1_mag    (s1_mag),
    .upper_rd  (upper_rd),
    .middle_rd (middle_rd),
    .dir_rd    (dir_rd),
    .s1_go     (s1_go),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata),
    .out_last  (out_tlast)
  );

endmodule

// ===== sv/enms_line_ram.sv =====
// Single-port-per-direction line store with a registered read.
// A read of the entry written in the same cycle returns the new data through
// a registered bypass. Depends on nothing.
module enms_line_ram #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int DW    = 34
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] mem_q_r;
  logic [DW-1:0] byp_data_r;
  logic          byp_sel_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_q_r    <= mem[rd_addr];
      byp_sel_r  <= wr_en && (wr_addr == rd_addr);
      byp_data_r <= wr_data;
    end
  end

  assign rd_data = byp_sel_r ? byp_data_r : mem_q_r;

endmodule

// ===== sv/enms_front.sv =====
// Address stage: frame geometry registers, raster position counters, angle
// quantizer and the pipeline register that waits for the line store data.
// Depends on enms_pkg.
module enms_front #(
  parameter int MAX_WIDTH = 1024,
  parameter int MAG_W     = 16,
  parameter int COL_W     = 10
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic                      cfg_idx,
  input  logic [enms_pkg::CFG_W-1:0] cfg_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [MAG_W-1:0]          in_mag,
  input  logic signed [15:0]        in_angle,
  input  logic                      in_frame_start,
  input  logic                      s1_go,
  output logic                      rd_en,
  output logic [COL_W-1:0]          rd_addr,
  output logic                      s1_valid,
  output logic [COL_W-1:0]          s1_col,
  output logic [MAG_W-1:0]          s1_mag,
  output enms_pkg::dir_t            s1_dir,
  output enms_pkg::pix_ctl_t        s1_ctl
);

  import enms_pkg::*;

  localparam int CW    = COL_W + 1;
  localparam int W_RST = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;

  logic [CW-1:0]    width_r, width_nxt;
  logic [CFG_W-1:0] height_r, height_nxt;
  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;

  logic             s1_v_r, s1_v_nxt;
  logic [COL_W-1:0] s1_col_r;
  logic [MAG_W-1:0] s1_mag_r;
  dir_t             s1_dir_r;
  pix_ctl_t         s1_ctl_r;

  logic             accept;
  logic [COL_W-1:0] col_a, cur_col, col_m1;
  logic [CFG_W-1:0] row_a;
  logic [ROW_W-1:0] cur_row;
  logic [CW-1:0]    col_inc;
  logic [CFG_W-1:0] row_inc;
  pix_ctl_t         ctl;

  assign in_ready = !s1_v_r || s1_go;
  assign accept   = in_valid && in_ready;

  // Geometry is clamped when written so the counters see legal bounds only.
  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    if (cfg_we) begin
      unique case (cfg_idx)
        CFG_IDX_WIDTH: begin
          if (cfg_data < CFG_W'(3))                width_nxt = CW'(3);
          else if (32'(cfg_data) > 32'(MAX_WIDTH)) width_nxt = CW'(MAX_WIDTH);
          else                                     width_nxt = CW'(cfg_data);
        end
        CFG_IDX_HEIGHT: begin
          if (cfg_data < CFG_W'(3))                 height_nxt = CFG_W'(3);
          else if (cfg_data > CFG_W'(MAX_HEIGHT))   height_nxt = CFG_W'(MAX_HEIGHT);
          else                                      height_nxt = cfg_data;
        end
        default: ;
      endcase
    end
  end

  // Position of the arriving pixel, then the position of the one after it.
  always_comb begin
    col_a = col_r;
    row_a = CFG_W'(row_r);
    if (CW'(col_r) >= width_r) begin
      col_a = '0;
      row_a = CFG_W'(row_r) + CFG_W'(1);
    end
    if (row_a >= height_r) row_a = '0;
    if (in_frame_start) begin
      col_a = '0;
      row_a = '0;
    end
    cur_col = col_a;
    cur_row = row_a[ROW_W-1:0];

    col_inc = CW'(cur_col) + CW'(1);
    row_inc = CFG_W'(cur_row) + CFG_W'(1);
    if (col_inc >= width_r) begin
      col_nxt = '0;
      row_nxt = (row_inc >= height_r) ? '0 : row_inc[ROW_W-1:0];
    end else begin
      col_nxt = col_inc[COL_W-1:0];
      row_nxt = cur_row;
    end

    col_m1   = cur_col - COL_W'(1);
    ctl.emit = (cur_row >= ROW_W'(2)) && (cur_col >= COL_W'(2));
    ctl.last = (CFG_W'(cur_row) == height_r - CFG_W'(1)) &&
               (CW'(cur_col) == width_r - CW'(1));
    ctl.row  = cur_row - ROW_W'(1);
    ctl.col  = COORD_W'(col_m1);
  end

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (accept)     s1_v_nxt = 1'b1;
    else if (s1_go) s1_v_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= CW'(W_RST);
      height_r <= CFG_W'(MAX_HEIGHT);
      col_r    <= '0;
      row_r    <= '0;
      s1_v_r   <= 1'b0;
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
      s1_v_r   <= s1_v_nxt;
      if (accept) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_col_r <= cur_col;
      s1_mag_r <= in_mag;
      s1_dir_r <= quantize(in_angle);
      s1_ctl_r <= ctl;
    end
  end

  assign rd_en    = accept;
  assign rd_addr  = cur_col;
  assign s1_valid = s1_v_r;
  assign s1_col   = s1_col_r;
  assign s1_mag   = s1_mag_r;
  assign s1_dir   = s1_dir_r;
  assign s1_ctl   = s1_ctl_r;

endmodule

// ===== sv/enms_window.sv =====
// 3x3 magnitude window, direction history, the neighbor comparison and the
// output register. Depends on enms_pkg.
module enms_window #(
  parameter int MAG_W = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           s1_valid,
  input  enms_pkg::pix_ctl_t             s1_ctl,
  input  logic [MAG_W-1:0]               s1_mag,
  input  logic [MAG_W-1:0]               upper_rd,
  input  logic [MAG_W-1:0]               middle_rd,
  input  enms_pkg::dir_t                 dir_rd,
  output logic                           s1_go,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [enms_pkg::OUT_DATA_W-1:0] out_data,
  output logic                           out_last
);

  import enms_pkg::*;

  logic [MAG_W-1:0] win_r [3][3];
  logic [MAG_W-1:0] win_nxt [3][3];
  dir_t             cdir_r [2];
  dir_t             cdir_nxt [2];

  logic             out_v_r, out_v_nxt;
  logic [FIELD_W-1:0] sup_r, sup_nxt;
  logic [COORD_W-1:0] orow_r, ocol_r;
  logic             olast_r;

  logic [MAG_W-1:0] center, nb_a, nb_b;
  logic             keep;

  // A pixel that yields no result never waits on the output register.
  assign s1_go = s1_valid && (!s1_ctl.emit || !out_v_r || out_ready);

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      win_nxt[k][0] = win_r[k][1];
      win_nxt[k][1] = win_r[k][2];
    end
    win_nxt[0][2] = upper_rd;
    win_nxt[1][2] = middle_rd;
    win_nxt[2][2] = s1_mag;
    cdir_nxt[0]   = dir_rd;
    cdir_nxt[1]   = cdir_r[0];

    center = win_nxt[1][1];
    unique case (cdir_nxt[1])
      DIR_HORZ:      begin nb_a = win_nxt[1][2]; nb_b = win_nxt[1][0]; end
      DIR_DIAG_UP:   begin nb_a = win_nxt[2][0]; nb_b = win_nxt[0][2]; end
      DIR_VERT:      begin nb_a = win_nxt[2][1]; nb_b = win_nxt[0][1]; end
      DIR_DIAG_DOWN: begin nb_a = win_nxt[0][0]; nb_b = win_nxt[2][2]; end
      default:       begin nb_a = win_nxt[1][2]; nb_b = win_nxt[1][0]; end
    endcase
    keep    = (center >= nb_a) && (center >= nb_b);
    sup_nxt = keep ? FIELD_W'(center) : '0;
  end

  always_comb begin
    out_v_nxt = out_v_r;
    if (s1_go && s1_ctl.emit) out_v_nxt = 1'b1;
    else if (out_ready)       out_v_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
      for (int k = 0; k < 3; k++) begin
        for (int j = 0; j < 3; j++) begin
          win_r[k][j] <= '0;
        end
      end
      cdir_r[0] <= DIR_HORZ;
      cdir_r[1] <= DIR_HORZ;
    end else begin
      out_v_r <= out_v_nxt;
      if (s1_go) begin
        win_r  <= win_nxt;
        cdir_r <= cdir_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_ctl.emit) begin
      sup_r   <= sup_nxt;
      orow_r  <= s1_ctl.row;
      ocol_r  <= s1_ctl.col;
      olast_r <= s1_ctl.last;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = {4'b0000, ocol_r, orow_r, sup_r};
  assign out_last  = olast_r;

endmodule

// ===== verif/tb.sv =====
// Self-checking bench for edge_non_max_suppression: directed frames, then random
// raster traffic under several frame geometries, checked beat by beat against
// a behavioral predictor. Depends on enms_pkg and the block's RTL only.
module tb;
  import enms_pkg::*;

  typedef struct packed {
    logic               last;
    logic [COORD_W-1:0] col;
    logic [ROW_W-1:0]   row;
    logic [15:0]        sup;
  } nms_result_t;

  typedef struct packed {
    logic [15:0]        mag;
    logic [15:0]        ang;
    logic               sof;
    logic               typed;
    logic [15:0]        sup;
    logic [ROW_W-1:0]   row;
    logic [COORD_W-1:0] col;
    logic               last;
  } directed_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic        cfg_idx = CFG_IDX_WIDTH;
  logic [10:0] cfg_data = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;   // magnitude[15:0], angle[31:16]
  logic        in_tuser = 1'b0; // frame_start
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;       // suppressed[15:0], out_row[25:16], out_col[35:26]
  logic        out_tlast;       // last

  edge_non_max_suppression dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always #1 clk = ~clk;

  initial begin
    #1000000;
    $display("edge_non_max_suppression verification failed");
    $finish;
  end

  // Predictor state, mirroring the block after reset.
  logic [10:0]  width_reg = 11'd1024;
  logic [10:0]  height_reg = 11'd1024;
  logic [15:0]  upper_mem [1024] = '{default: '0};
  logic [15:0]  middle_mem [1024] = '{default: '0};
  dir_t         dir_mem [1024] = '{default: DIR_HORZ};
  logic [15:0]  win [3][3] = '{default: '0};
  dir_t         center_dir [2] = '{DIR_HORZ, DIR_HORZ};
  int unsigned  row_pos = 0;
  int unsigned  col_pos = 0;

  nms_result_t  pending_beats [$];
  int           mismatch_count = 0;
  int           burst_left = 1;
  logic [11:0]  stall_cycle = '0;

  int angle_edges [19] = '{3216, 3217, 9650, 9651, 16084, 16085, 22518, 22519,
                           -22519, -22518, -16085, -16084, -9651, -9650, -3217,
                           -3216, 0, 25736, -25736};

  // Two frames 3 wide, 4 high: two interior pixels each, one per direction in all.
  directed_row_t directed_rows [24] = '{
    '{16'd0,     16'sd25736,  1'b1, 1'b0, 16'd0,     10'd0, 10'd0, 1'b0},
    '{16'd0,     -16'sd25736, 1'b0, 1'b0, 16'd0,     10'd0, 10'd0, 1'b0},
    '{16'd0,     16'sd3216,   1'b0, 1'b0, 16'd0,     10'd0, 10'd0, 1'b0},
    '{16'd0,     16'sd3217,   1'b0, 1'b0, 16'd0,     10'd0, 10'd0, 1'b0},
    '{16'd65535, 16'sh8000,   1'b0, 1'b0, 16'd0,     10'd0, 10'd0, 1'b0},
    '{16'd0,     16'sd9650,   1'b0, 1'b0, 16'd0,     10'd0, 10'd0, 1'b0},
    '{16'd0,     16'sd9651,   1'b0, 1'b0, 16'd0,     10'd0, 10'd0, 1'b0},
    '{16'd500,   16'sd6000,   1'b0, 1'b0, 16'd0,     10'd0, 10'd0, 1'b0},
    '{16'd0,     16'sd16084,  1'b0, 1'b1, 16'd65535, 10'd1, 10'd1, 1'b0},
    '{16'd501,   16'sd16085,  1'b0, 1'b0, 16'd0,     10'd0, 10'd0, 1'b0},
    '{16'd0,     16'sd22518,  1'b0, 1'b0, 16'd0,     10'd0, 10'd0, 1'b0},
    '{16'd0,     16'sd22519,  1'b0, 1'b1, 16'd0,     10'd2, 10'd1, 1'b1},
    '{16'd0,     -16'sd22519, 1'b1, 1'b0, 16'd0,     10'd0, 10'd0, 1'b0},
    '{16'd1000,  -16'sd22518, 1'b0, 1'b0, 16'd0,     10'd0, 10'd0, 1'b0},
    '{16'd0,     -16'sd16085, 1'b0, 1'b0, 16'd0,     10'd0, 10'd0, 1'b0},
    '{16'd0,     -16'sd16084, 1'b0, 1'b0, 16'd0,     10'd0, 10'd0, 1'b0},
    '{16'd1000,  16'sd12000,  1'b0, 1'b0, 16'd0,     10'd0, 10'd0, 1'b0},
    '{16'd0,     -16'sd9651,  1'b0, 1'b0, 16'd0,     10'd0, 10'd0, 1'b0},
    '{16'd0,     -16'sd9650,  1'b0, 1'b0, 16'd0,     10'd0, 10'd0, 1'b0},
    '{16'd999,   -16'sd6000,  1'b0, 1'b0, 16'd0,     10'd0, 10'd0, 1'b0},
    '{16'd0,     -16'sd3217,  1'b0, 1'b1, 16'd1000,  10'd1, 10'd1, 1'b0},
    '{16'd0,     -16'sd3216,  1'b0, 1'b0, 16'd0,     10'd0, 10'd0, 1'b0},
    '{16'd0,     16'sd32767,  1'b0, 1'b0, 16'd0,     10'd0, 10'd0, 1'b0},
    '{16'd1000,  16'sd0,      1'b0, 1'b1, 16'd0,     10'd2, 10'd1, 1'b1}
  };

  function automatic int unsigned clamp_dim(input logic [10:0] v, input int unsigned hi);
    if (v < 3) return 3;
    if (v > hi) return hi;
    return 32'(v);
  endfunction

  // Negative angles fold by pi; adding 25735 puts the negative sector edges
  // exactly on the positive ones, so one threshold ladder serves both halves.
  function automatic dir_t sector_of(input logic signed [15:0] a);
    int folded;
    folded = (a < 0) ? int'(a) + 25735 : int'(a);
    if (folded <= 3216 || folded > 22518) return DIR_HORZ;
    if (folded <= 9650) return DIR_DIAG_UP;
    if (folded <= 16084) return DIR_VERT;
    return DIR_DIAG_DOWN;
  endfunction

  function automatic bit suppress_step(input logic [15:0] mag, input logic [15:0] ang,
                                       input logic sof, output nms_result_t res);
    int unsigned w, h, r, c;
    logic [15:0] center, along_a, along_b;
    bit fired;
    w = clamp_dim(width_reg, 1024);
    h = clamp_dim(height_reg, MAX_HEIGHT);
    res = '0;
    fired = 1'b0;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
    end
    if (row_pos >= h) row_pos = 0;
    if (sof) begin
      row_pos = 0;
      col_pos = 0;
    end
    r = row_pos;
    c = col_pos;
    for (int k = 0; k < 3; k++) begin
      win[k][0] = win[k][1];
      win[k][1] = win[k][2];
    end
    win[0][2] = upper_mem[c];
    win[1][2] = middle_mem[c];
    win[2][2] = mag;
    center_dir[1] = center_dir[0];
    center_dir[0] = dir_mem[c];
    upper_mem[c] = middle_mem[c];
    middle_mem[c] = mag;
    dir_mem[c] = sector_of(ang);
    if (r >= 2 && c >= 2) begin
      center = win[1][1];
      case (center_dir[1])
        DIR_HORZ: begin
          along_a = win[1][2];
          along_b = win[1][0];
        end
        DIR_DIAG_UP: begin
          along_a = win[2][0];
          along_b = win[0][2];
        end
        DIR_VERT: begin
          along_a = win[2][1];
          along_b = win[0][1];
        end
        default: begin
          along_a = win[0][0];
          along_b = win[2][2];
        end
      endcase
      res.sup = (center >= along_a && center >= along_b) ? center : 16'd0;
      res.row = ROW_W'(r - 1);
      res.col = COORD_W'(c - 1);
      res.last = (r == h - 1 && c == w - 1);
      fired = 1'b1;
    end
    col_pos = c + 1;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos = r + 1;
      if (row_pos >= h) row_pos = 0;
    end
    return fired;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d, expected %0d", what, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk) begin : result_check
    nms_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_beats.size() == 0) begin
        report_mismatch("result beat with nothing pending", out_tdata[15:0], 0);
      end else begin
        want = pending_beats.pop_front();
        if (out_tdata[15:0] !== want.sup)
          report_mismatch("suppressed", out_tdata[15:0], want.sup);
        if (out_tdata[25:16] !== want.row)
          report_mismatch("out_row", out_tdata[25:16], want.row);
        if (out_tdata[35:26] !== want.col)
          report_mismatch("out_col", out_tdata[35:26], want.col);
        if (out_tlast !== want.last)
          report_mismatch("last", out_tlast, want.last);
      end
    end
  end

  // The receiver rotates through always-ready, light, heavy and coin-flip stalls.
  always @(posedge clk) begin
    stall_cycle <= stall_cycle + 1'b1;
    case (stall_cycle[9:8])
      2'd0: out_tready <= 1'b1;
      2'd1: out_tready <= ($urandom_range(0, 3) != 0);
      2'd2: out_tready <= (stall_cycle[2:0] < 3'd2);
      default: out_tready <= ($urandom_range(0, 1) == 1);
    endcase
  end

  task automatic write_reg(input logic idx, input logic [10:0] value);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_IDX_WIDTH) width_reg = value;
    else height_reg = value;
    @(posedge clk);
  endtask

  task automatic send_pixel(input logic [15:0] mag, input logic [15:0] ang, input logic sof,
                            input bit typed, input nms_result_t typed_res);
    nms_result_t res;
    bit fired;
    int idle;
    in_tvalid <= 1'b1;
    in_tdata <= {ang, mag};
    in_tuser <= sof;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    fired = suppress_step(mag, ang, sof, res);
    if (typed) pending_beats = {pending_beats, typed_res};
    else if (fired) pending_beats = {pending_beats, res};
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 48);
      idle = $urandom_range(0, 5);
      if (idle > 0) begin
        in_tvalid <= 1'b0;
        repeat (idle) @(posedge clk);
      end
    end
  endtask

  // Let every pending result out, then give the pipeline time to go quiet.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic void random_pixel(output logic [15:0] mag, output logic [15:0] ang);
    case ($urandom_range(0, 7))
      0, 1, 2, 3: mag = 16'($urandom_range(0, 65535));
      4, 5:       mag = 16'($urandom_range(0, 7));
      6:          mag = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      default:    mag = 16'($urandom_range(65528, 65535));
    endcase
    case ($urandom_range(0, 7))
      0, 1, 2, 6, 7: ang = 16'($urandom_range(0, 51472) - 25736);
      3, 4:          ang = 16'(angle_edges[$urandom_range(0, 18)]);
      default:       ang = 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // One geometry: write width (and height if set_h) while idle, then a raster of
  // random pixels, with a rare stray frame start as noise when noise is set.
  task automatic run_phase(input logic [10:0] w, input logic [10:0] h, input bit set_h,
                           input bit restart, input bit noise, input int count,
                           input bit pause_midway);
    logic [15:0] mag, ang;
    logic sof;
    write_reg(CFG_IDX_WIDTH, w);
    if (set_h) write_reg(CFG_IDX_HEIGHT, h);
    for (int n = 0; n < count; n++) begin
      random_pixel(mag, ang);
      sof = (n == 0 && restart) || (noise && $urandom_range(0, 149) == 0);
      if (pause_midway && n == count / 2) drain_results();
      send_pixel(mag, ang, sof, 1'b0, '0);
    end
    drain_results();
  endtask

  initial begin : stimulus
    nms_result_t typed_res;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_reg(CFG_IDX_WIDTH, 11'd3);
    write_reg(CFG_IDX_HEIGHT, 11'd4);
    foreach (directed_rows[i]) begin
      typed_res.sup = directed_rows[i].sup;
      typed_res.row = directed_rows[i].row;
      typed_res.col = directed_rows[i].col;
      typed_res.last = directed_rows[i].last;
      send_pixel(directed_rows[i].mag, directed_rows[i].ang, directed_rows[i].sof,
                 directed_rows[i].typed, typed_res);
    end
    drain_results();

    run_phase(11'd5, 11'd6, 1'b1, 1'b1, 1'b1, 80, 1'b1);
    // An oversized width clamps to full rows; the frame stops a few pixels
    // into its second row, so the row reached depends on the clamp.
    run_phase(11'd2047, 11'd3, 1'b1, 1'b1, 1'b0, 1030, 1'b0);
    // Narrowing mid-frame without a frame start wraps the raster position.
    run_phase(11'd0, 11'd0, 1'b0, 1'b0, 1'b1, 60, 1'b0);
    run_phase(11'd1, 11'd2047, 1'b1, 1'b1, 1'b1, 60, 1'b0);
    run_phase(11'd17, 11'd0, 1'b1, 1'b1, 1'b1, 80, 1'b0);
    run_phase(11'd2, 11'd2, 1'b1, 1'b1, 1'b1, 60, 1'b0);
    run_phase(11'd4, 11'd5, 1'b1, 1'b1, 1'b1, 60, 1'b0);

    if (mismatch_count == 0) begin
      $display("edge_non_max_suppression verification clean");
    end else begin
      $display("edge_non_max_suppression verification failed");
    end
    $finish;
  end

endmodule

// ===== edge_non_max_suppression.f =====
sv/enms_pkg.sv
sv/enms_line_ram.sv
sv/enms_front.sv
sv/enms_window.sv
sv/edge_non_max_suppression.sv
verif/tb.sv
